// File: src/pah_pkg.sv
// ---------------------------------------------------------------------------
// pah_pkg: shared types and constants for the packed allele histogram
// Item layouts, command codes, register indexes and counter geometry.
// ---------------------------------------------------------------------------
package pah_pkg;

    localparam int NUM_POS  = 4096;
    localparam int POS_W    = 12;
    localparam int LIM_W    = 13;
    localparam int CNT_W    = 32;
    localparam int NUM_SYM  = 4;
    localparam int ROW_W    = CNT_W * NUM_SYM;
    localparam int LANE_W   = 6;
    localparam int CFG_W    = 13;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_COUNT = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic REG_BPS   = 1'b0;
    localparam logic REG_GSIZE = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [6:0]  block_index;
        logic [63:0] block_data;
        logic [11:0] position;
    } req_t;

    typedef struct packed {
        logic [31:0] count_sym0;
        logic [31:0] count_sym1;
        logic [31:0] count_sym2;
        logic [31:0] count_sym3;
        logic        status;
    } rsp_t;

endpackage

// File: src/pah_ram.sv
// ---------------------------------------------------------------------------
// pah_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module pah_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: src/packed_allele_histogram_top.sv
// ---------------------------------------------------------------------------
// packed_allele_histogram_top: per-position symbol histogram
// Counters live in one RAM row per position (four 32-bit counters per row).
// One item at a time; the count loop does one read-modify-write per lane
// through the single RAM write port. After reset a clearing pass zeroes the
// RAM; no item is taken during it (configuration writes are). Registers
// reset to 2 and 4096.
// ---------------------------------------------------------------------------
module packed_allele_histogram_top
    import pah_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  req_t             req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_t             rsp,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    typedef enum logic [2:0] {S_IDLE, S_CLR, S_CNT, S_FIN, S_RDW} state_t;

    state_t              state_reg;
    logic [1:0]          bps_reg;
    logic [LIM_W-1:0]    gsize_reg;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;
    logic [POS_W-1:0]    clr_addr_reg;
    logic                clr_rsp_reg;
    logic [LANE_W-1:0]   lane_reg;
    logic [63:0]         data_reg;
    logic [LIM_W-1:0]    base_reg;
    logic                cnt_status_reg;
    logic                s1_valid_reg;
    logic [POS_W-1:0]    s1_addr_reg;
    logic [1:0]          s1_sym_reg;

    logic                one_bit;
    logic [LIM_W-1:0]    limit;
    logic [LIM_W-1:0]    cur_pos;
    logic                cur_in;
    logic                last_lane;
    logic [1:0]          cur_sym;
    logic [LIM_W-1:0]    req_base;
    logic [CNT_W-1:0]    old_cnt;
    logic [ROW_W-1:0]    new_row;
    logic                ram_we;
    logic [POS_W-1:0]    ram_waddr;
    logic [ROW_W-1:0]    ram_wdata;
    logic [POS_W-1:0]    ram_raddr;
    logic [ROW_W-1:0]    ram_rdata;
    logic                accept;

    // decode mode and position limit
    assign one_bit   = (bps_reg == 2'd1);
    assign limit     = (gsize_reg > LIM_W'(NUM_POS)) ? LIM_W'(NUM_POS) : gsize_reg;
    assign req_base  = one_bit ? {req.block_index, 6'd0} : {1'b0, req.block_index, 5'd0};
    assign cur_pos   = base_reg + LIM_W'(lane_reg);
    assign cur_in    = (cur_pos < limit);
    assign last_lane = one_bit ? (lane_reg == 6'd63) : (lane_reg == 6'd31);
    assign cur_sym   = one_bit ? {1'b0, data_reg[0]} : data_reg[1:0];

    assign accept    = req_valid && req_ready;
    assign req_ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // bump the selected counter, saturating
    always_comb
    begin
        old_cnt = ram_rdata[s1_sym_reg*CNT_W +: CNT_W];
        new_row = ram_rdata;
        if (old_cnt != {CNT_W{1'b1}})
        begin
            new_row[s1_sym_reg*CNT_W +: CNT_W] = old_cnt + CNT_W'(1);
        end
    end

    // RAM port selection
    always_comb
    begin
        ram_we    = (state_reg == S_CLR) || s1_valid_reg;
        ram_waddr = (state_reg == S_CLR) ? clr_addr_reg : s1_addr_reg;
        ram_wdata = (state_reg == S_CLR) ? '0 : new_row;
        ram_raddr = (state_reg == S_CNT) ? cur_pos[POS_W-1:0] : req.position;
    end

    pah_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_POS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // payload registers of the count loop
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= req.block_data;
            base_reg <= req_base;
        end
        else if (state_reg == S_CNT)
        begin
            data_reg <= one_bit ? {1'b0, data_reg[63:1]} : {2'b00, data_reg[63:2]};
        end
        s1_addr_reg <= cur_pos[POS_W-1:0];
        s1_sym_reg  <= cur_sym;
    end

    // control, configuration and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            bps_reg        <= 2'd2;
            gsize_reg      <= LIM_W'(NUM_POS);
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
            clr_addr_reg   <= '0;
            clr_rsp_reg    <= 1'b0;
            lane_reg       <= '0;
            cnt_status_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            // take configuration writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BPS:   bps_reg   <= cfg_data[1:0];
                    REG_GSIZE: gsize_reg <= cfg_data;
                    default:   ;
                endcase
            end

            // drop the result once taken
            if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            s1_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (req.cmd)
                            CMD_CLEAR:
                            begin
                                state_reg    <= S_CLR;
                                clr_addr_reg <= '0;
                                clr_rsp_reg  <= 1'b1;
                            end
                            CMD_COUNT:
                            begin
                                state_reg      <= S_CNT;
                                lane_reg       <= '0;
                                cnt_status_reg <= (req_base >= limit);
                            end
                            CMD_READ:
                            begin
                                if (LIM_W'(req.position) < limit)
                                begin
                                    state_reg <= S_RDW;
                                end
                                else
                                begin
                                    rsp_reg        <= '0;
                                    rsp_reg.status <= 1'b1;
                                    rsp_valid_reg  <= 1'b1;
                                end
                            end
                            default:
                            begin
                                rsp_reg       <= '0;
                                rsp_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_CLR:
                begin
                    clr_addr_reg <= clr_addr_reg + POS_W'(1);
                    if (clr_addr_reg == POS_W'(NUM_POS - 1))
                    begin
                        state_reg <= S_IDLE;
                        if (clr_rsp_reg)
                        begin
                            rsp_reg       <= '0;
                            rsp_valid_reg <= 1'b1;
                        end
                    end
                end
                S_CNT:
                begin
                    // issue one lane read; the write follows in the next cycle
                    s1_valid_reg <= cur_in;
                    lane_reg     <= lane_reg + LANE_W'(1);
                    if (last_lane || !cur_in)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    state_reg      <= S_IDLE;
                    rsp_reg        <= '0;
                    rsp_reg.status <= cnt_status_reg;
                    rsp_valid_reg  <= 1'b1;
                end
                S_RDW:
                begin
                    state_reg          <= S_IDLE;
                    rsp_reg.count_sym0 <= ram_rdata[0*CNT_W +: CNT_W];
                    rsp_reg.count_sym1 <= ram_rdata[1*CNT_W +: CNT_W];
                    rsp_reg.count_sym2 <= one_bit ? '0 : ram_rdata[2*CNT_W +: CNT_W];
                    rsp_reg.count_sym3 <= one_bit ? '0 : ram_rdata[3*CNT_W +: CNT_W];
                    rsp_reg.status     <= 1'b0;
                    rsp_valid_reg      <= 1'b1;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
